### hw/rtl/vaps_pkg.sv
`default_nettype none

package vaps_pkg;

  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int GAIN_W      = 20;
  localparam int FRAC_W      = 15;
  localparam int ANGLE_W     = 16;
  localparam int TURN_W      = 16;
  localparam int REG_IDX_W   = ADDR_W - 2;

  // shared multiplier b operand: unsigned gain plus a sign bit
  localparam int MUL_B_W     = GAIN_W + 1;

  localparam int EMA_SHIFT   = 8;
  localparam int EMA_ROUND   = 128;
  localparam int GAIN_SHIFT  = 16;

  localparam logic signed [MUL_B_W-1:0] EMA_NEW = MUL_B_W'(51);
  localparam logic signed [MUL_B_W-1:0] EMA_OLD = MUL_B_W'(205);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_STEER_GAIN      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_GAIN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TURN_FLOOR      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TURN_LIMIT      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEADBAND        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_WINDOW = 3'd5;

  localparam logic [GAIN_W-1:0] RST_STEER_GAIN      = 20'd167772;
  localparam logic [GAIN_W-1:0] RST_INTEGRAL_GAIN   = 20'd10486;
  localparam logic [FRAC_W-1:0] RST_TURN_FLOOR      = 15'd2294;
  localparam logic [FRAC_W-1:0] RST_TURN_LIMIT      = 15'd9830;
  localparam logic [FRAC_W-1:0] RST_DEADBAND        = 15'd128;
  localparam logic [FRAC_W-1:0] RST_INTEGRAL_WINDOW = 15'd512;

  typedef struct packed {
    logic [GAIN_W-1:0] steer_gain;
    logic [GAIN_W-1:0] integral_gain;
    logic [FRAC_W-1:0] turn_floor;
    logic [FRAC_W-1:0] turn_limit;
    logic [FRAC_W-1:0] deadband;
    logic [FRAC_W-1:0] integral_window;
  } cfg_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EMA_A = 8'b0000_0010,
    S_EMA_B = 8'b0000_0100,
    S_EMA_C = 8'b0000_1000,
    S_INT   = 8'b0001_0000,
    S_MUL_I = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_CLAMP = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/vaps_regs.sv
`default_nettype none

module vaps_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vaps_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [vaps_pkg::DATA_W-1:0]  pwdata,
  output logic      [vaps_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output vaps_pkg::cfg_t                    cfg_o
);

  vaps_pkg::cfg_t                      cfg_q, cfg_d;
  logic [vaps_pkg::REG_IDX_W-1:0]      idx;
  logic                                wr_en;

  assign idx    = paddr[vaps_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        vaps_pkg::REG_STEER_GAIN:      cfg_d.steer_gain      = pwdata[vaps_pkg::GAIN_W-1:0];
        vaps_pkg::REG_INTEGRAL_GAIN:   cfg_d.integral_gain   = pwdata[vaps_pkg::GAIN_W-1:0];
        vaps_pkg::REG_TURN_FLOOR:      cfg_d.turn_floor      = pwdata[vaps_pkg::FRAC_W-1:0];
        vaps_pkg::REG_TURN_LIMIT:      cfg_d.turn_limit      = pwdata[vaps_pkg::FRAC_W-1:0];
        vaps_pkg::REG_DEADBAND:        cfg_d.deadband        = pwdata[vaps_pkg::FRAC_W-1:0];
        vaps_pkg::REG_INTEGRAL_WINDOW: cfg_d.integral_window = pwdata[vaps_pkg::FRAC_W-1:0];
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      vaps_pkg::REG_STEER_GAIN:      prdata = vaps_pkg::DATA_W'(cfg_q.steer_gain);
      vaps_pkg::REG_INTEGRAL_GAIN:   prdata = vaps_pkg::DATA_W'(cfg_q.integral_gain);
      vaps_pkg::REG_TURN_FLOOR:      prdata = vaps_pkg::DATA_W'(cfg_q.turn_floor);
      vaps_pkg::REG_TURN_LIMIT:      prdata = vaps_pkg::DATA_W'(cfg_q.turn_limit);
      vaps_pkg::REG_DEADBAND:        prdata = vaps_pkg::DATA_W'(cfg_q.deadband);
      vaps_pkg::REG_INTEGRAL_WINDOW: prdata = vaps_pkg::DATA_W'(cfg_q.integral_window);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steer_gain      <= vaps_pkg::RST_STEER_GAIN;
      cfg_q.integral_gain   <= vaps_pkg::RST_INTEGRAL_GAIN;
      cfg_q.turn_floor      <= vaps_pkg::RST_TURN_FLOOR;
      cfg_q.turn_limit      <= vaps_pkg::RST_TURN_LIMIT;
      cfg_q.deadband        <= vaps_pkg::RST_DEADBAND;
      cfg_q.integral_window <= vaps_pkg::RST_INTEGRAL_WINDOW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/vaps_mul.sv
`default_nettype none

module vaps_mul #(
  parameter int A_W = 40
) (
  input  wire logic                                    clk_i,
  input  wire logic signed [A_W-1:0]                   a_i,
  input  wire logic signed [vaps_pkg::MUL_B_W-1:0]     b_i,
  output logic signed      [A_W+vaps_pkg::MUL_B_W-1:0] prod_o
);

  logic signed [A_W+vaps_pkg::MUL_B_W-1:0] prod_q, prod_d;

  assign prod_d = (A_W+vaps_pkg::MUL_B_W)'(a_i) * (A_W+vaps_pkg::MUL_B_W)'(b_i);
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

endmodule

`default_nettype wire

### hw/rtl/vision_aim_pi_steering.sv
`default_nettype none

// PI turn controller for vision aiming. Each request is one camera reading
// (target offset and target-valid bit) and yields exactly one turn command.
// A reading with a target is worked through a single shared signed
// multiplier that is used four times in turn (the two filter taps, the
// proportional gain and the integral gain), so it occupies the block from
// acceptance until the result register holds the command, and no further
// reading is taken before then, also while a full result register stalls it;
// a reading without a target produces a zero command in the next cycle.
// The next reading is taken as soon as the block is idle and the result
// register is empty or being drained in that cycle. The filtered offset and
// integral sum are cleared by reset and hold while no target is seen.
// Registers sit at byte addresses 0x00 steer_gain, 0x04 integral_gain,
// 0x08 turn_floor, 0x0C turn_limit, 0x10 deadband, 0x14 integral_window;
// write them only while no request is in flight.
module vision_aim_pi_steering #(
  parameter int OFFSET_WIDTH   = 16,
  parameter int INTEGRAL_WIDTH = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [vaps_pkg::ADDR_W-1:0]  paddr,
  input  wire logic        [vaps_pkg::DATA_W-1:0]  pwdata,
  output logic             [vaps_pkg::DATA_W-1:0]  prdata,
  output logic                                     pready,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [vaps_pkg::ANGLE_W-1:0] angle_offset_i,
  input  wire logic                                target_valid_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed      [vaps_pkg::TURN_W-1:0]  turn_command_o,
  output logic                                     has_target_o
);

  localparam int MW0 = (OFFSET_WIDTH > INTEGRAL_WIDTH) ? OFFSET_WIDTH : INTEGRAL_WIDTH;
  localparam int MW  = (MW0 > vaps_pkg::ANGLE_W) ? MW0 : vaps_pkg::ANGLE_W;
  localparam int PW  = MW + vaps_pkg::MUL_B_W;
  localparam int AW  = PW + 1;

  localparam logic signed [AW-1:0] F_HI = AW'((64'sd1 <<< (OFFSET_WIDTH - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] F_LO = ~F_HI;
  localparam logic signed [AW-1:0] I_HI = AW'((64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] I_LO = ~I_HI;

  vaps_pkg::cfg_t cfg;

  vaps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vaps_pkg::state_e                        state_q, state_d;
  logic                                    out_valid_q, out_valid_d;
  logic signed [OFFSET_WIDTH-1:0]          filt_q, filt_d;
  logic signed [INTEGRAL_WIDTH-1:0]        integ_q, integ_d;
  logic signed [vaps_pkg::ANGLE_W-1:0]     x_q, x_d;
  logic signed [AW-1:0]                    acc_q, acc_d;
  logic signed [AW-1:0]                    cmd_q, cmd_d;
  logic signed [vaps_pkg::TURN_W-1:0]      turn_q, turn_d;
  logic                                    has_q, has_d;
  logic                                    active_q, active_d;
  logic                                    pos_q, pos_d;

  logic signed [MW-1:0]                    mul_a;
  logic signed [vaps_pkg::MUL_B_W-1:0]     mul_b;
  logic signed [PW-1:0]                    prod;

  logic                                    in_fire, out_room, load_out;
  logic signed [AW-1:0] ema_sum, ema_sh, f_ext, f_mag, int_sum;
  logic signed [AW-1:0] db_ext, win_ext, min_ext, lim_ext, p_sh;

  vaps_mul #(
    .A_W (MW)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign out_room   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == vaps_pkg::S_IDLE) && out_room;
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o    = out_valid_q;
  assign turn_command_o = turn_q;
  assign has_target_o   = has_q;

  assign db_ext  = AW'($signed({1'b0, cfg.deadband}));
  assign win_ext = AW'($signed({1'b0, cfg.integral_window}));
  assign min_ext = AW'($signed({1'b0, cfg.turn_floor}));
  assign lim_ext = AW'($signed({1'b0, cfg.turn_limit}));

  assign ema_sum = acc_q + AW'(prod) + AW'(vaps_pkg::EMA_ROUND);
  assign ema_sh  = ema_sum >>> vaps_pkg::EMA_SHIFT;
  assign f_ext   = AW'(filt_q);
  assign f_mag   = f_ext[AW-1] ? -f_ext : f_ext;
  assign int_sum = AW'(integ_q) + f_ext;
  assign p_sh    = AW'(prod) >>> vaps_pkg::GAIN_SHIFT;

  // multiplier operand select
  always_comb begin
    unique case (state_q)
      vaps_pkg::S_EMA_A: begin
        mul_a = MW'(x_q);
        mul_b = vaps_pkg::EMA_NEW;
      end
      vaps_pkg::S_EMA_B: begin
        mul_a = MW'(filt_q);
        mul_b = vaps_pkg::EMA_OLD;
      end
      vaps_pkg::S_MUL_I: begin
        mul_a = MW'(integ_q);
        mul_b = $signed({1'b0, cfg.integral_gain});
      end
      default: begin
        mul_a = MW'(filt_q);
        mul_b = $signed({1'b0, cfg.steer_gain});
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    filt_d   = filt_q;
    integ_d  = integ_q;
    x_d      = x_q;
    acc_d    = acc_q;
    cmd_d    = cmd_q;
    turn_d   = turn_q;
    has_d    = has_q;
    active_d = active_q;
    pos_d    = pos_q;
    load_out = 1'b0;

    unique case (state_q)
      vaps_pkg::S_IDLE: begin
        if (in_fire) begin
          x_d = angle_offset_i;
          if (target_valid_i) begin
            state_d = vaps_pkg::S_EMA_A;
          end else begin
            load_out = 1'b1;
            turn_d   = '0;
            has_d    = 1'b0;
          end
        end
      end
      vaps_pkg::S_EMA_A: begin
        state_d = vaps_pkg::S_EMA_B;
      end
      vaps_pkg::S_EMA_B: begin
        acc_d   = AW'(prod);
        state_d = vaps_pkg::S_EMA_C;
      end
      vaps_pkg::S_EMA_C: begin
        if (ema_sh > F_HI) begin
          filt_d = OFFSET_WIDTH'(F_HI);
        end else if (ema_sh < F_LO) begin
          filt_d = OFFSET_WIDTH'(F_LO);
        end else begin
          filt_d = OFFSET_WIDTH'(ema_sh);
        end
        state_d = vaps_pkg::S_INT;
      end
      vaps_pkg::S_INT: begin
        // outside the outer window or inside the deadband the integral resets
        if (f_mag > win_ext || f_mag < db_ext) begin
          integ_d = '0;
        end else if (int_sum > I_HI) begin
          integ_d = INTEGRAL_WIDTH'(I_HI);
        end else if (int_sum < I_LO) begin
          integ_d = INTEGRAL_WIDTH'(I_LO);
        end else begin
          integ_d = INTEGRAL_WIDTH'(int_sum);
        end
        active_d = f_mag > db_ext;
        pos_d    = !f_ext[AW-1];
        state_d  = vaps_pkg::S_MUL_I;
      end
      vaps_pkg::S_MUL_I: begin
        acc_d   = p_sh;
        state_d = vaps_pkg::S_SUM;
      end
      vaps_pkg::S_SUM: begin
        if (active_q) begin
          cmd_d = acc_q + p_sh + (pos_q ? min_ext : -min_ext);
        end else begin
          cmd_d = '0;
        end
        state_d = vaps_pkg::S_CLAMP;
      end
      vaps_pkg::S_CLAMP: begin
        if (out_room) begin
          load_out = 1'b1;
          has_d    = 1'b1;
          if (cmd_q > lim_ext) begin
            turn_d = vaps_pkg::TURN_W'(lim_ext);
          end else if (cmd_q < -lim_ext) begin
            turn_d = vaps_pkg::TURN_W'(-lim_ext);
          end else begin
            turn_d = vaps_pkg::TURN_W'(cmd_q);
          end
          state_d = vaps_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = vaps_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vaps_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      filt_q      <= '0;
      integ_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      filt_q      <= filt_d;
      integ_q     <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    acc_q    <= acc_d;
    cmd_q    <= cmd_d;
    turn_q   <= turn_d;
    has_q    <= has_d;
    active_q <= active_d;
    pos_q    <= pos_d;
  end

endmodule

`default_nettype wire

### hw/rtl/vaps_checker.sv
`default_nettype none

module vaps_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic                                target_valid_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [vaps_pkg::TURN_W-1:0]  turn_command_o,
  input wire logic                                has_target_o
);

  logic in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // a request without a target answers in the next cycle with a zero command
  a_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !target_valid_i |=> out_valid_o && !has_target_o && turn_command_o == '0)
    else $error("no-target request did not give a zero result");

  // a request with a target keeps the block busy and the output empty
  a_target_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && target_valid_i |=> !out_valid_o && !in_ready_o)
    else $error("target request did not occupy the block");

  // a no-target result always carries a zero command
  a_zero_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_target_o |-> turn_command_o == '0)
    else $error("nonzero command without a target");

endmodule

bind vision_aim_pi_steering vaps_checker u_vaps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .target_valid_i (target_valid_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .turn_command_o (turn_command_o),
  .has_target_o   (has_target_o)
);

`default_nettype wire
